// File: src/mft_pkg.sv
// shared types, codes and the bucket hash of the multicast filter table
package mft_pkg;

  localparam int unsigned DEF_TABLE_ENTRIES = 16;
  localparam int unsigned ADDR_W            = 48;
  localparam int unsigned REFS_W            = 16;
  localparam int unsigned BUCKET_W          = 6;
  localparam int unsigned SLICES            = ADDR_W / BUCKET_W;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;
  localparam logic [REFS_W-1:0] REFS_ONE = REFS_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_BCAST = '1;

  typedef enum logic [1:0] {
    OP_ADD      = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_CLASSIFY = 2'd2,
    OP_RESET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_RES    = 2'd1,
    ST_NOT_SUP   = 2'd2,
    ST_BAD_STATE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_RESET = 2'd3
  } cmd_e;

  typedef struct packed {
    op_e               operation;
    logic [ADDR_W-1:0] address;
  } in_item_t;

  typedef struct packed {
    status_e             status;
    cmd_e                hash_command;
    logic [BUCKET_W-1:0] bucket;
    logic                is_broadcast;
    logic                is_multicast;
    logic                deliver;
  } out_item_t;

  // one table entry as held in memory
  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic [REFS_W-1:0] refs;
  } entry_t;

  // outcome of comparing one entry against the request address
  typedef struct packed {
    logic              in_use;
    logic              hit;
    logic              same_bucket;
    logic [REFS_W-1:0] refs;
  } cmp_t;

  // xor of the eight 6-bit slices
  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [ADDR_W-1:0] a);
    logic [BUCKET_W-1:0] h;
    h = '0;
    for (int k = 0; k < SLICES; k++) begin
      h = h ^ a[BUCKET_W*k +: BUCKET_W];
    end
    return h;
  endfunction

endpackage

// File: src/mft_ram.sv
// generic simple dual-port ram, registered read
module mft_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/mft_entry_cmp.sv
// compares one table entry read from memory against the request address
module mft_entry_cmp import mft_pkg::*; (
  input  entry_t            entry_i,
  input  logic              valid_i,
  input  logic [ADDR_W-1:0] address_i,
  output cmp_t              cmp_o
);

  logic addr_eq;
  logic bkt_eq;

  assign addr_eq = (entry_i.address == address_i);
  assign bkt_eq  = (bucket_of(entry_i.address) == bucket_of(address_i));

  // an entry without its valid bit reads as free
  assign cmp_o.in_use      = valid_i;
  assign cmp_o.hit         = valid_i && addr_eq;
  assign cmp_o.same_bucket = valid_i && bkt_eq && !addr_eq;
  assign cmp_o.refs        = valid_i ? entry_i.refs : '0;

endmodule

// File: src/multicast_filter_table_unit.sv
// top level of the refcounted multicast address filter table
// add, remove and classify scan every entry between the accepting edge and the edge
// that takes the result; the next item is taken at that same edge
// the single memory read port scans one entry per cycle
// table reset skips the scan; the result strobe is one cycle wide, never stalled
// reset empties the table through per-entry valid bits and sets hash_capable to 1
module multicast_filter_table_unit import mft_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = DEF_TABLE_ENTRIES
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  // command channel
  input  logic      start,
  output logic      busy,
  input  in_item_t  req_i,
  // result strobe and payload
  output logic      done_o,
  output out_item_t rsp_o,
  // hash_capable register write channel
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_TAIL,
    S_COMMIT
  } state_e;

  state_e    state_q;
  in_item_t  req_q;
  logic      hash_cap_q;

  // scan bookkeeping
  logic [CntW-1:0]   scan_q;      // next entry to read
  logic              rd_pend_q;   // memory data valid this cycle
  logic [IdxW-1:0]   ridx_q;      // entry that the memory data belongs to
  logic              vrd_q;       // its valid bit, read alongside
  logic              have_free_q;
  logic [IdxW-1:0]   free_idx_q;
  logic              have_slot_q;
  logic [IdxW-1:0]   slot_idx_q;
  logic [REFS_W-1:0] slot_refs_q;
  logic              used_q;      // another live entry shares the bucket

  // table state kept in flops
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CntW-1:0]          count_q;

  // result register
  logic      done_q;
  out_item_t rsp_q;

  // memory port signals
  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  entry_t          ram_wdata;
  logic            ram_re;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t          rd_ent;
  cmp_t            cmp;

  // commit decisions
  logic            commit;
  logic            wr_en;
  logic            set_vld;
  logic            clr_vld;
  logic            cnt_inc;
  logic            cnt_dec;
  logic            clear_all;
  out_item_t       rsp_d;
  logic            bcast;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign rsp_o       = rsp_q;

  // one read per cycle during the scan
  assign ram_re = (state_q == S_SCAN);
  assign rd_ent = entry_t'(ram_rdata);

  mft_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(scan_q[IdxW-1:0]),
    .rdata_o(ram_rdata)
  );

  mft_entry_cmp u_cmp (
    .entry_i  (rd_ent),
    .valid_i  (vrd_q),
    .address_i(req_q.address),
    .cmp_o    (cmp)
  );

  // work out the write-back and the result from the scan summary
  assign commit = (state_q == S_COMMIT);
  assign bcast  = (req_q.address == ADDR_BCAST);

  always_comb begin
    wr_en     = 1'b0;
    ram_waddr = free_idx_q;
    ram_wdata = '{address: req_q.address, refs: REFS_ONE};
    set_vld   = 1'b0;
    clr_vld   = 1'b0;
    cnt_inc   = 1'b0;
    cnt_dec   = 1'b0;
    clear_all = 1'b0;
    rsp_d     = '{status: ST_OK, hash_command: CMD_NONE, bucket: '0,
                  is_broadcast: 1'b0, is_multicast: 1'b0, deliver: 1'b0};
    case (req_q.operation)
      OP_ADD: begin
        if (have_slot_q) begin
          // existing member: bump the count unless it is pinned
          if (slot_refs_q == REFS_MAX) begin
            rsp_d.status = ST_NO_RES;
          end else begin
            wr_en          = 1'b1;
            ram_waddr      = slot_idx_q;
            ram_wdata.refs = slot_refs_q + REFS_ONE;
          end
        end else if (!have_free_q) begin
          rsp_d.status = ST_NO_RES;
        end else if ((count_q == '0) && !hash_cap_q) begin
          rsp_d.status = ST_NOT_SUP;
        end else begin
          // new member in the lowest free entry
          wr_en   = 1'b1;
          set_vld = 1'b1;
          cnt_inc = 1'b1;
          if (!used_q) begin
            rsp_d.hash_command = CMD_SET;
            rsp_d.bucket       = bucket_of(req_q.address);
          end
        end
      end
      OP_REMOVE: begin
        if (!have_slot_q) begin
          rsp_d.status = ST_BAD_STATE;
        end else if (slot_refs_q == REFS_ONE) begin
          // last reference gone: entry becomes free
          clr_vld = 1'b1;
          cnt_dec = (count_q != '0);
          if (!used_q) begin
            rsp_d.hash_command = CMD_CLEAR;
            rsp_d.bucket       = bucket_of(req_q.address);
          end
        end else begin
          wr_en          = 1'b1;
          ram_waddr      = slot_idx_q;
          ram_wdata.refs = slot_refs_q - REFS_ONE;
        end
      end
      OP_CLASSIFY: begin
        rsp_d.is_broadcast  = bcast;
        rsp_d.is_multicast  = req_q.address[0] && !bcast;
        // exact miss on a multicast group drops the frame
        rsp_d.deliver = !(req_q.address[0] && !bcast) || have_slot_q;
      end
      OP_RESET: begin
        clear_all = 1'b1;
        if (hash_cap_q) begin
          rsp_d.hash_command = CMD_RESET;
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we = commit && wr_en;

  // sequencer, scan summary, valid bits, count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      hash_cap_q  <= 1'b1;
      scan_q      <= '0;
      rd_pend_q   <= 1'b0;
      ridx_q      <= '0;
      vrd_q       <= 1'b0;
      have_free_q <= 1'b0;
      free_idx_q  <= '0;
      have_slot_q <= 1'b0;
      slot_idx_q  <= '0;
      slot_refs_q <= '0;
      used_q      <= 1'b0;
      valid_q     <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
      rsp_q       <= '0;
    end else begin
      // result strobe follows the commit cycle
      done_q <= commit;
      if (cfg_valid_i && cfg_ready_o) begin
        hash_cap_q <= cfg_data_i;
      end

      // fold in the entry read in the previous cycle
      if (rd_pend_q) begin
        if (!have_slot_q) begin
          if (!cmp.in_use && !have_free_q) begin
            have_free_q <= 1'b1;
            free_idx_q  <= ridx_q;
          end
          if (cmp.hit) begin
            have_slot_q <= 1'b1;
            slot_idx_q  <= ridx_q;
            slot_refs_q <= cmp.refs;
          end
        end
        if (cmp.same_bucket) begin
          used_q <= 1'b1;
        end
      end

      case (state_q)
        S_IDLE: begin
          rd_pend_q <= 1'b0;
          if (start) begin
            req_q       <= req_i;
            scan_q      <= '0;
            have_free_q <= 1'b0;
            have_slot_q <= 1'b0;
            used_q      <= 1'b0;
            state_q     <= (req_i.operation == OP_RESET) ? S_COMMIT : S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend_q <= 1'b1;
          ridx_q    <= scan_q[IdxW-1:0];
          vrd_q     <= valid_q[scan_q[IdxW-1:0]];
          scan_q    <= scan_q + CntW'(1);
          if (scan_q == LastIdx) begin
            state_q <= S_TAIL;
          end
        end
        S_TAIL: begin
          rd_pend_q <= 1'b0;
          state_q   <= S_COMMIT;
        end
        S_COMMIT: begin
          rd_pend_q <= 1'b0;
          if (clear_all) begin
            valid_q <= '0;
            count_q <= '0;
          end else begin
            if (set_vld) begin
              valid_q[free_idx_q] <= 1'b1;
            end
            if (clr_vld) begin
              valid_q[slot_idx_q] <= 1'b0;
            end
            if (cnt_inc) begin
              count_q <= count_q + CntW'(1);
            end else if (cnt_dec) begin
              count_q <= count_q - CntW'(1);
            end
          end
          rsp_q   <= rsp_d;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: src/mft_checker.sv
// port-level checks on the multicast filter table, bound to the top level
module mft_checker import mft_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input out_item_t rsp_o
);

  // every accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after an accepted command");

  // a result closes a busy period
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy && $past(busy))
    else $error("result strobe outside the end of a command");

  // a bucket is named only by a set or clear command
  a_bucket_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.hash_command != CMD_SET && rsp_o.hash_command != CMD_CLEAR
      |-> rsp_o.bucket == '0)
    else $error("bucket without set or clear command");

  // a failing command never touches the hash filter
  a_fail_no_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.hash_command == CMD_NONE)
    else $error("hash command on a failed command");

  // classify flags are exclusive
  a_class_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.is_broadcast |-> !rsp_o.is_multicast && rsp_o.deliver)
    else $error("broadcast also flagged multicast or dropped");

endmodule

bind multicast_filter_table_unit mft_checker u_mft_checker (
  .clk_i (clk_i),
  .rst_ni(rst_ni),
  .start (start),
  .busy  (busy),
  .done_o(done_o),
  .rsp_o (rsp_o)
);

// File: sim/tb.sv
// testbench for the multicast filter table: directed and random membership traffic
`timescale 1ns / 1ps

module tb;
  import mft_pkg::*;

  localparam int unsigned TABLE_N = DEF_TABLE_ENTRIES;
  // cycles with no transfer at all before the run is declared hung
  localparam int unsigned HANG_LIMIT = 2000;
  // quiet cycles after the last result before a register write or a resumed burst
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_PHASES = 6;
  localparam int unsigned PHASE_OPS = 175;
  localparam int unsigned POOL_N = 20;
  // back-to-back adds of one group address
  localparam int unsigned REPEAT_ADDS = 20;

  typedef enum logic [1:0] {
    JOB_OP,
    JOB_CFG,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e kind;
    in_item_t  item;
    logic      cfg_val;
    bit        rush;
  } job_t;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  in_item_t  req;
  logic      done_o;
  out_item_t rsp;
  logic      cfg_valid;
  logic      cfg_ready;
  logic      cfg_data;

  multicast_filter_table_unit #(
    .TABLE_ENTRIES(TABLE_N)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done_o),
    .rsp_o      (rsp),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  // free-running clock, 8 ns period
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // shadow of the filter table, updated at each accepted command
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] tab_addr [TABLE_N];
  logic [REFS_W-1:0] tab_refs [TABLE_N];
  int unsigned       tab_live;
  logic              hash_en;

  // pending work for the driver and responses still owed by the block
  job_t        pending_ops [$];
  out_item_t   expected_rsp [$];
  int unsigned n_accepted;
  int unsigned n_results;
  int unsigned err_cnt;

  // xor fold of the address, six bits at a time
  function automatic logic [BUCKET_W-1:0] fold_bucket(logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0]   v;
    logic [BUCKET_W-1:0] h;
    v = a;
    h = '0;
    repeat (ADDR_W / BUCKET_W) begin
      h ^= v[BUCKET_W-1:0];
      v = v >> BUCKET_W;
    end
    return h;
  endfunction

  function automatic bit bucket_live(logic [BUCKET_W-1:0] b);
    for (int i = 0; i < TABLE_N; i++) begin
      if (tab_refs[i] != '0 && fold_bucket(tab_addr[i]) == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void wipe_table();
    for (int i = 0; i < TABLE_N; i++) begin
      tab_addr[i] = '0;
      tab_refs[i] = '0;
    end
    tab_live = 0;
  endfunction

  // applies one command to the shadow table and returns the response it owes
  function automatic out_item_t predict_response(in_item_t it);
    out_item_t           r;
    int                  free_i;
    int                  slot_i;
    bit                  hit;
    logic [BUCKET_W-1:0] b;
    r = '0;
    free_i = -1;
    slot_i = -1;
    hit = 1'b0;
    case (it.operation)
      OP_ADD, OP_REMOVE: begin
        // first free entry below the match, and the matching live entry
        for (int i = 0; i < TABLE_N; i++) begin
          if (slot_i < 0) begin
            if (tab_refs[i] == '0) begin
              if (free_i < 0) free_i = i;
            end else if (tab_addr[i] == it.address) begin
              slot_i = i;
            end
          end
        end
        if (it.operation == OP_ADD) begin
          if (slot_i >= 0) begin
            // refcount saturates at all ones
            if (tab_refs[slot_i] == REFS_MAX) r.status = ST_NO_RES;
            else tab_refs[slot_i] = tab_refs[slot_i] + 1'b1;
          end else if (free_i < 0) begin
            r.status = ST_NO_RES;
          end else if (tab_live == 0 && !hash_en) begin
            r.status = ST_NOT_SUP;
          end else begin
            b = fold_bucket(it.address);
            if (!bucket_live(b)) begin
              r.hash_command = CMD_SET;
              r.bucket = b;
            end
            tab_addr[free_i] = it.address;
            tab_refs[free_i] = REFS_ONE;
            tab_live++;
          end
        end else begin
          if (slot_i < 0) begin
            r.status = ST_BAD_STATE;
          end else begin
            tab_refs[slot_i] = tab_refs[slot_i] - 1'b1;
            if (tab_refs[slot_i] == '0) begin
              b = fold_bucket(tab_addr[slot_i]);
              tab_addr[slot_i] = '0;
              if (tab_live != 0) tab_live--;
              if (!bucket_live(b)) begin
                r.hash_command = CMD_CLEAR;
                r.bucket = b;
              end
            end
          end
        end
      end
      OP_CLASSIFY: begin
        r.is_broadcast = (it.address == ADDR_BCAST);
        r.is_multicast = it.address[0] && !r.is_broadcast;
        r.deliver = 1'b1;
        if (r.is_multicast) begin
          // exact match only, a shared bucket does not count
          for (int i = 0; i < TABLE_N; i++) begin
            if (tab_refs[i] != '0 && tab_addr[i] == it.address) hit = 1'b1;
          end
          r.deliver = hit;
        end
      end
      default: begin
        if (hash_en) r.hash_command = CMD_RESET;
        wipe_table();
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(op_e op, logic [ADDR_W-1:0] a, bit rush = 1'b0);
    job_t j;
    j.kind = JOB_OP;
    j.item.operation = op;
    j.item.address = a;
    j.cfg_val = 1'b0;
    j.rush = rush;
    pending_ops.push_back(j);
  endtask

  task automatic queue_cfg(logic v);
    job_t j;
    j.kind = JOB_CFG;
    j.item = '0;
    j.cfg_val = v;
    j.rush = 1'b0;
    pending_ops.push_back(j);
  endtask

  task automatic queue_drain();
    job_t j;
    j.kind = JOB_DRAIN;
    j.item = '0;
    j.cfg_val = 1'b0;
    j.rush = 1'b0;
    pending_ops.push_back(j);
  endtask

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  // address with the same bucket: flip the same bits in the two lowest slices,
  // keeping the group bit
  function automatic logic [ADDR_W-1:0] bucket_mate(logic [ADDR_W-1:0] a);
    logic [BUCKET_W-1:0] m;
    m = BUCKET_W'($urandom_range(1, 31) << 1);
    return a ^ ADDR_W'({m, m});
  endfunction

  // ---------------------------------------------------------------------------
  // driver: feeds commands and register writes from pending_ops
  // ---------------------------------------------------------------------------
  job_t        head;
  logic        start_nx;
  logic        cfg_valid_nx;
  int unsigned quiet;
  int unsigned gap_left;
  int unsigned burst_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start      <= 1'b0;
      req        <= '0;
      cfg_valid  <= 1'b0;
      cfg_data   <= 1'b0;
      quiet      = 0;
      gap_left   = 0;
      burst_left = 0;
      n_accepted = 0;
      // shadow starts like the block: empty table, hash support on
      hash_en    = 1'b1;
      wipe_table();
    end else begin
      start_nx = start;
      cfg_valid_nx = cfg_valid;
      // command transfer: predict now so the shadow follows acceptance order
      if (start && !busy) begin
        expected_rsp.push_back(predict_response(req));
        n_accepted++;
        start_nx = 1'b0;
      end
      // register transfer
      if (cfg_valid && cfg_ready) begin
        hash_en = cfg_data;
        cfg_valid_nx = 1'b0;
        void'(pending_ops.pop_front());
      end
      if (!start_nx && !cfg_valid_nx && pending_ops.size() > 0) begin
        head = pending_ops[0];
        if (head.kind == JOB_OP) begin
          quiet = 0;
          if (gap_left > 0 && !head.rush) begin
            gap_left--;
          end else begin
            start_nx = 1'b1;
            req <= head.item;
            void'(pending_ops.pop_front());
            if (burst_left > 0) begin
              burst_left--;
            end else begin
              // next burst; some long stretches with no gap at all
              burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
              gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
          end
        end else begin
          // register writes and pauses wait until every response is back
          if (n_accepted == n_results) quiet++;
          else quiet = 0;
          if (quiet >= SETTLE_CYCLES) begin
            quiet = 0;
            if (head.kind == JOB_CFG) begin
              cfg_valid_nx = 1'b1;
              cfg_data <= head.cfg_val;
            end else begin
              void'(pending_ops.pop_front());
            end
          end
        end
      end
      start <= start_nx;
      cfg_valid <= cfg_valid_nx;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result strobe is checked against the oldest expectation
  // ---------------------------------------------------------------------------
  out_item_t want;
  bit        bad;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_results <= 0;
      err_cnt = 0;
    end else if (done_o) begin
      n_results <= n_results + 1;
      if (expected_rsp.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) begin
          $display("unexpected result: st=%0d cmd=%0d bkt=%0d bc=%b mc=%b sel=%b",
                   rsp.status, rsp.hash_command, rsp.bucket,
                   rsp.is_broadcast, rsp.is_multicast, rsp.deliver);
        end
      end else begin
        want = expected_rsp.pop_front();
        bad = (rsp.status !== want.status) || (rsp.hash_command !== want.hash_command) ||
              (rsp.bucket !== want.bucket) || (rsp.is_broadcast !== want.is_broadcast) ||
              (rsp.is_multicast !== want.is_multicast) ||
              (rsp.deliver !== want.deliver);
        if (bad) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("mismatch at result %0d: want st=%0d cmd=%0d bkt=%0d bc=%b mc=%b sel=%b",
                     n_results, want.status, want.hash_command, want.bucket,
                     want.is_broadcast, want.is_multicast, want.deliver);
            $display("                      got  st=%0d cmd=%0d bkt=%0d bc=%b mc=%b sel=%b",
                     rsp.status, rsp.hash_command, rsp.bucket,
                     rsp.is_broadcast, rsp.is_multicast, rsp.deliver);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: stops a run in which nothing moves for too long
  // ---------------------------------------------------------------------------
  int unsigned hang_cnt;

  always @(posedge clk_i) begin
    if (!rst_ni) hang_cnt <= 0;
    else if ((start && !busy) || done_o || (cfg_valid && cfg_ready)) hang_cnt <= 0;
    else hang_cnt <= hang_cnt + 1;
    if (hang_cnt >= HANG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  logic [ADDR_W-1:0] grp_a;
  logic [ADDR_W-1:0] grp_b;
  logic [ADDR_W-1:0] grp_c;
  logic [ADDR_W-1:0] sat_a;
  logic [ADDR_W-1:0] pool [POOL_N];
  int unsigned       pick;

  initial begin
    rst_ni = 1'b0;

    grp_a = rand_addr() | ADDR_W'(1);
    grp_b = bucket_mate(grp_a);
    grp_c = bucket_mate(grp_a);
    while (grp_c == grp_b) grp_c = bucket_mate(grp_a);

    // first add into an empty table without hash support
    queue_cfg(1'b0);
    queue_op(OP_ADD, grp_a);
    queue_cfg(1'b1);
    // classify on an empty table: broadcast, unicast, multicast miss
    queue_op(OP_CLASSIFY, ADDR_BCAST);
    queue_op(OP_CLASSIFY, '0);
    queue_op(OP_CLASSIFY, grp_a);
    queue_op(OP_REMOVE, grp_a);
    // shared bucket: one set on the way in, one clear on the way out
    queue_op(OP_ADD, grp_a);
    queue_op(OP_ADD, grp_a);
    queue_op(OP_ADD, grp_b);
    queue_op(OP_CLASSIFY, grp_a);
    queue_op(OP_CLASSIFY, grp_c);
    queue_op(OP_REMOVE, grp_a);
    queue_op(OP_REMOVE, grp_a);
    queue_op(OP_REMOVE, grp_b);
    // table full, with hash support off once the table is not empty
    queue_op(OP_ADD, ADDR_BCAST);
    queue_cfg(1'b0);
    queue_op(OP_ADD, '0);
    queue_op(OP_ADD, ADDR_W'(6'h3f));
    for (int i = 0; i < TABLE_N - 3; i++) queue_op(OP_ADD, rand_addr());
    queue_op(OP_ADD, grp_c);
    queue_op(OP_RESET, rand_addr());
    queue_cfg(1'b1);
    queue_op(OP_RESET, '0);

    // repeated adds of one group, sent back to back
    sat_a = rand_addr() | ADDR_W'(1);
    for (int i = 0; i < REPEAT_ADDS; i++) queue_op(OP_ADD, sat_a, 1'b1);
    queue_op(OP_ADD, sat_a);
    queue_op(OP_CLASSIFY, sat_a);
    queue_op(OP_REMOVE, sat_a);
    queue_op(OP_RESET, ADDR_BCAST);
    queue_drain();

    // random phases over a small address pool so the table fills and empties
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      queue_cfg((p < 2) ? logic'(p == 0) : logic'($urandom_range(0, 1)));
      for (int k = 0; k < POOL_N; k++) begin
        if (k > 0 && $urandom_range(0, 3) == 0) begin
          pool[k] = bucket_mate(pool[$urandom_range(0, k - 1)]);
        end else begin
          pool[k] = rand_addr();
          if ($urandom_range(0, 4) != 0) pool[k][0] = 1'b1;
        end
      end
      for (int n = 0; n < PHASE_OPS; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) queue_op(OP_ADD, pool[$urandom_range(0, POOL_N - 1)]);
        else if (pick < 62) queue_op(OP_REMOVE, pool[$urandom_range(0, POOL_N - 1)]);
        else if (pick < 68) queue_op(OP_REMOVE, rand_addr());
        else if (pick < 86) queue_op(OP_CLASSIFY, pool[$urandom_range(0, POOL_N - 1)]);
        else if (pick < 90) queue_op(OP_CLASSIFY, ADDR_BCAST);
        else if (pick < 97) queue_op(OP_CLASSIFY, rand_addr());
        else queue_op(OP_RESET, rand_addr());
        // occasional pause until the block has answered everything
        if (n % 60 == 59) queue_drain();
      end
    end

    // release reset away from the rising edge
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // wait for the backlog to empty and every response to come back
    while (pending_ops.size() != 0 || start || cfg_valid || n_accepted != n_results) begin
      @(posedge clk_i);
    end
    repeat (TABLE_N + 8) @(posedge clk_i);

    if (err_cnt == 0 && expected_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
